@@ sv/pts_pkg.sv @@
// Package for the priority thread scheduler: sizes, codes, payload and chain types.
// No dependencies; every other file imports it.
package pts_pkg;

  localparam int MAX_THREADS = 16;
  localparam int IDX_W = $clog2(MAX_THREADS);
  localparam int CNT_W = $clog2(MAX_THREADS + 1);
  localparam int KEY_W = 72;

  // item kinds
  localparam logic [3:0] K_CREATE  = 4'd0;
  localparam logic [3:0] K_RESUME  = 4'd1;
  localparam logic [3:0] K_SUSPEND = 4'd2;
  localparam logic [3:0] K_CANCEL  = 4'd3;
  localparam logic [3:0] K_SEND    = 4'd4;
  localparam logic [3:0] K_DISP    = 4'd5;
  localparam logic [3:0] K_STEP    = 4'd6;
  localparam logic [3:0] K_SHUT    = 4'd7;
  localparam logic [3:0] K_REAP    = 4'd8;
  localparam logic [3:0] K_QUERY   = 4'd9;

  // result status
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_REJ   = 3'd1;
  localparam logic [2:0] ST_DISP  = 3'd2;
  localparam logic [2:0] ST_EXEC  = 3'd3;
  localparam logic [2:0] ST_IDLE  = 3'd4;
  localparam logic [2:0] ST_SUSP  = 3'd5;
  localparam logic [2:0] ST_SHUT  = 3'd6;
  localparam logic [2:0] ST_ALARM = 3'd7;

  // thread states
  localparam logic [2:0] TS_SUSPENDED  = 3'd0;
  localparam logic [2:0] TS_READY      = 3'd1;
  localparam logic [2:0] TS_RUNNING    = 3'd2;
  localparam logic [2:0] TS_SLEEPING   = 3'd3;
  localparam logic [2:0] TS_WAITQ      = 3'd4;
  localparam logic [2:0] TS_WAITJOIN   = 3'd5;
  localparam logic [2:0] TS_TERMINATED = 3'd6;
  localparam logic [2:0] TS_CANCELLED  = 3'd7;

  // step outcomes
  localparam logic [2:0] A_YIELD = 3'd0;
  localparam logic [2:0] A_SLEEP = 3'd1;
  localparam logic [2:0] A_WAITQ = 3'd2;
  localparam logic [2:0] A_JOIN  = 3'd3;
  localparam logic [2:0] A_EXIT  = 3'd4;

  // register select bit of paddr
  localparam logic REG_BACKGROUND = 1'b0;
  localparam logic REG_RETRACE    = 1'b1;

  // operation a pass through the cell row performs
  typedef enum logic [3:0] {
    M_CREATE, M_RESUME, M_SUSPEND, M_CANCEL, M_PROBE,
    M_PICK_READY, M_PICK_WAITQ, M_MIN_SLEEP,
    M_READY_AT, M_RUN_AT, M_SET_AT,
    M_WAKE_DUE, M_WAKE_JOIN, M_SHUTDOWN, M_REAP
  } pts_mode_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] thread_id;
    logic [7:0]  priority_req;
    logic        create_held;
    logic [63:0] queue_key;
    logic [2:0]  action_kind;
    logic [63:0] action_value;
  } pts_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] result_id;
    logic [2:0]  thread_state;
    logic [7:0]  thread_priority;
    logic [63:0] exit_value;
    logic        retrace_fire;
    logic [63:0] retrace_count;
    logic [63:0] logical_tick;
  } pts_rsp_t;

  // broadcast command held for the length of a pass
  typedef struct packed {
    pts_mode_t        mode;
    logic [IDX_W-1:0] target;
    logic [63:0]      val;
    logic [2:0]       state;
    logic [7:0]       prio;
    logic             susp;
    logic [31:0]      ident;
  } pts_cmd_t;

  // token handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic             ok;
    logic [CNT_W-1:0] count;
    logic             best_valid;
    logic [IDX_W-1:0] best_idx;
    logic [KEY_W-1:0] best_key;
  } pts_tok_t;

  // slot fields visible to the read port
  typedef struct packed {
    logic        used;
    logic [31:0] ident;
    logic [7:0]  prio;
    logic [2:0]  state;
    logic [63:0] exit_val;
  } pts_view_t;

endpackage

@@ sv/pts_cell.sv @@
// One thread slot of the scheduler row; acts on the token as it passes.
// Depends on pts_pkg.
module pts_cell
  import pts_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] cell_idx,
  input  pts_cmd_t         cmd,
  input  logic [63:0]      order_base,
  input  pts_tok_t         tok_in,
  output pts_tok_t         tok_out,
  output pts_view_t        view
);

  logic        used, used_next;
  logic [31:0] ident, ident_next;
  logic [7:0]  prio, prio_next;
  logic [2:0]  state, state_next;
  logic [63:0] order, order_next;
  logic [63:0] wake, wake_next;
  logic [63:0] wkey, wkey_next;
  logic [63:0] exit_val, exit_next;
  pts_tok_t    tok_next;

  logic             fin, claim, at, cand, mark;
  logic [KEY_W-1:0] ckey;
  logic [63:0]      my_order;

  always_comb begin
    fin      = (state == TS_TERMINATED) || (state == TS_CANCELLED);
    claim    = used && ({32'd0, ident} == cmd.val) && !tok_in.hit;
    at       = (cell_idx == cmd.target);
    my_order = order_base + {{(64-CNT_W){1'b0}}, tok_in.count};
    cand     = 1'b0;
    mark     = 1'b0;
    ckey     = {8'd0, wake};
    used_next  = used;
    ident_next = ident;
    prio_next  = prio;
    state_next = state;
    order_next = order;
    wake_next  = wake;
    wkey_next  = wkey;
    exit_next  = exit_val;
    tok_next   = tok_in;
    if (tok_in.valid) begin
      unique case (cmd.mode)
        M_CREATE: begin
          if (!used && !tok_in.hit) begin
            tok_next.hit = 1'b1;
            tok_next.ok  = 1'b1;
            used_next  = 1'b1;
            ident_next = cmd.ident;
            prio_next  = cmd.prio;
            state_next = cmd.susp ? TS_SUSPENDED : TS_READY;
            order_next = cmd.susp ? 64'd0 : my_order;
            wake_next  = '0;
            wkey_next  = '0;
            exit_next  = '0;
            if (!cmd.susp) tok_next.count = tok_in.count + 1'b1;
          end
        end
        M_RESUME: begin
          if (claim) begin
            tok_next.hit = 1'b1;
            if (!fin) begin
              tok_next.ok = 1'b1;
              mark = 1'b1;
            end
          end
        end
        M_SUSPEND, M_CANCEL: begin
          if (claim) begin
            tok_next.hit = 1'b1;
            if (!fin && state != TS_RUNNING) begin
              tok_next.ok = 1'b1;
              state_next = (cmd.mode == M_SUSPEND) ? TS_SUSPENDED : TS_CANCELLED;
            end
          end
        end
        M_PROBE: begin
          if (claim) begin
            tok_next.hit      = 1'b1;
            tok_next.ok       = !fin;
            tok_next.best_idx = cell_idx;
          end
        end
        M_PICK_READY: begin
          cand = used && state == TS_READY;
          ckey = {prio, order};
        end
        M_PICK_WAITQ: begin
          cand = used && state == TS_WAITQ && wkey == cmd.val;
          ckey = {prio, order};
        end
        M_MIN_SLEEP: cand = used && state == TS_SLEEPING;
        M_READY_AT:  mark = at;
        M_RUN_AT:    if (at) state_next = TS_RUNNING;
        M_SET_AT: begin
          if (at) begin
            state_next = cmd.state;
            if (cmd.state == TS_SLEEPING) wake_next = cmd.val;
            if (cmd.state == TS_WAITQ || cmd.state == TS_WAITJOIN) wkey_next = cmd.val;
            if (cmd.state == TS_TERMINATED) exit_next = cmd.val;
          end
        end
        M_WAKE_DUE:  mark = used && state == TS_SLEEPING && wake <= cmd.val;
        M_WAKE_JOIN: mark = used && state == TS_WAITJOIN && wkey == cmd.val;
        M_SHUTDOWN:  if (used && state != TS_TERMINATED) state_next = TS_CANCELLED;
        M_REAP:      if (used && fin) used_next = 1'b0;
        default: ;
      endcase
      if (mark) begin
        state_next = TS_READY;
        order_next = my_order;
        wake_next  = '0;
        wkey_next  = '0;
        tok_next.count = tok_in.count + 1'b1;
      end
      if (cand && (!tok_in.best_valid || ckey < tok_in.best_key)) begin
        tok_next.best_valid = 1'b1;
        tok_next.best_idx   = cell_idx;
        tok_next.best_key   = ckey;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used          <= 1'b0;
      tok_out.valid <= 1'b0;
    end else begin
      used          <= used_next;
      tok_out.valid <= tok_next.valid;
    end
    ident    <= ident_next;
    prio     <= prio_next;
    state    <= state_next;
    order    <= order_next;
    wake     <= wake_next;
    wkey     <= wkey_next;
    exit_val <= exit_next;
    tok_out.hit        <= tok_next.hit;
    tok_out.ok         <= tok_next.ok;
    tok_out.count      <= tok_next.count;
    tok_out.best_valid <= tok_next.best_valid;
    tok_out.best_idx   <= tok_next.best_idx;
    tok_out.best_key   <= tok_next.best_key;
  end

  assign view = '{used: used, ident: ident, prio: prio, state: state, exit_val: exit_val};

endmodule

@@ sv/pts_div.sv @@
// Restoring divider, one quotient bit per cycle: 64-bit dividend by 32-bit divisor.
// Depends on pts_pkg (imported for house style; uses no package items beyond that).
module pts_div
  import pts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quot
);

  logic [31:0] rem;
  logic [31:0] dsr;
  logic [6:0]  cnt;
  logic        active;
  logic [32:0] shifted;
  logic        take;

  assign shifted = {rem, quot[63]};
  assign take    = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        active <= 1'b1;
        cnt    <= '0;
        rem    <= '0;
        quot   <= dividend;
        dsr    <= divisor;
      end else if (active) begin
        rem  <= take ? 32'(shifted - {1'b0, dsr}) : shifted[31:0];
        quot <= {quot[62:0], take};
        cnt  <= cnt + 1'b1;
        if (cnt == 7'd63) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

@@ sv/priority_thread_scheduler.sv @@
// Priority thread scheduler: a row of slot cells driven by a pass sequencer; needs pts_pkg,
// pts_cell and pts_div. A pass carries one token through all cells of the row. An item takes
// 0 to 4 passes, none for a rejection with no search; a firing retrace also runs the divider.
// Throughput: one item at a time; the next may start in the strobe cycle. No receiver stall.
// Reset: synchronous, active high; clears slot-used bits and all counters, ids start at 1.
module priority_thread_scheduler
  import pts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  pts_req_t    req,
  output logic        done,
  output pts_rsp_t    rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // sequencer steps; most of them launch a pass and wait for its token to leave the row
  typedef enum logic [15:0] {
    S_IDLE   = 16'b0000_0000_0000_0001,
    S_CREATE = 16'b0000_0000_0000_0010,
    S_CLAIM  = 16'b0000_0000_0000_0100,
    S_LAST   = 16'b0000_0000_0000_1000,
    S_QREAD  = 16'b0000_0000_0001_0000,
    S_SEND   = 16'b0000_0000_0010_0000,
    S_WAKE1  = 16'b0000_0000_0100_0000,
    S_PICK   = 16'b0000_0000_1000_0000,
    S_RUN    = 16'b0000_0001_0000_0000,
    S_MINS   = 16'b0000_0010_0000_0000,
    S_SLIVE  = 16'b0000_0100_0000_0000,
    S_SPROBE = 16'b0000_1000_0000_0000,
    S_SEXIT  = 16'b0001_0000_0000_0000,
    S_STEPW  = 16'b0010_0000_0000_0000,
    S_RET    = 16'b0100_0000_0000_0000,
    S_DIV    = 16'b1000_0000_0000_0000
  } pts_state_t;

  pts_state_t st;
  pts_req_t   q;
  pts_cmd_t   cmd;
  logic       launch;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] run_slot;
  logic [31:0] run_ident;
  logic [31:0] next_ident;
  logic [63:0] next_order;
  logic [63:0] tick;
  logic [63:0] opcnt;
  logic [63:0] next_at;
  logic        shut;
  logic        pending;
  logic        bg;
  logic [31:0] period;
  logic        div_go;
  logic        div_done;
  logic [63:0] div_quot;

  // result fields held until the next item
  logic [2:0]  r_status;
  logic [31:0] r_id;
  logic [2:0]  r_state;
  logic [7:0]  r_prio;
  logic [63:0] r_exit;
  logic        r_fire;
  logic [63:0] r_index;

  // cell row: tok[i] enters cell i, tok[MAX_THREADS] is the end of a pass
  pts_tok_t  tok [0:MAX_THREADS];
  pts_view_t views [0:MAX_THREADS-1];
  pts_view_t rd;
  pts_tok_t  tend;
  logic      pass_done;
  logic [MAX_THREADS:0] tok_vld;

  assign tok[0] = '{valid: launch, default: '0};

  for (genvar i = 0; i < MAX_THREADS; i++) begin : g_cell
    pts_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_idx   (IDX_W'(i)),
      .cmd        (cmd),
      .order_base (next_order),
      .tok_in     (tok[i]),
      .tok_out    (tok[i+1]),
      .view       (views[i])
    );
  end

  for (genvar i = 0; i <= MAX_THREADS; i++) begin : g_vld
    assign tok_vld[i] = tok[i].valid;
  end

  assign tend      = tok[MAX_THREADS];
  assign pass_done = tend.valid;
  assign rd        = views[rd_idx];

  pts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (opcnt),
    .divisor  (period),
    .done     (div_done),
    .quot     (div_quot)
  );

  logic        cfg_wr;
  logic        live;
  logic [63:0] sleep_to;
  logic [63:0] alarm_tick;

  assign cfg_wr     = psel && penable && pwrite && pready;
  assign pready     = 1'b1;
  assign prdata     = (paddr[2] == REG_RETRACE) ? period : {31'd0, bg};
  assign busy       = (st != S_IDLE);
  assign live       = rd.used && (rd.ident == run_ident);
  assign sleep_to   = (q.action_value > tick) ? q.action_value : tick;
  assign alarm_tick = (tend.best_key[63:0] > tick) ? tend.best_key[63:0] : tick;

  assign rsp = '{status: r_status, result_id: r_id, thread_state: r_state,
                 thread_priority: r_prio, exit_value: r_exit, retrace_fire: r_fire,
                 retrace_count: r_index, logical_tick: tick};

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= S_IDLE;
      launch     <= 1'b0;
      done       <= 1'b0;
      div_go     <= 1'b0;
      shut       <= 1'b0;
      pending    <= 1'b0;
      next_ident <= 32'd1;
      next_order <= '0;
      tick       <= '0;
      opcnt      <= '0;
      next_at    <= '0;
      run_slot   <= '0;
      run_ident  <= '0;
      bg         <= 1'b0;
      period     <= '0;
    end else begin
      launch <= 1'b0;
      done   <= 1'b0;
      div_go <= 1'b0;
      // every pass hands back how many ready orders it used up
      if (pass_done) next_order <= next_order + {{(64-CNT_W){1'b0}}, tend.count};
      if (cfg_wr) begin
        if (paddr[2] == REG_BACKGROUND) begin
          bg <= pwdata[0];
        end else begin
          period  <= pwdata;
          next_at <= opcnt + {32'd0, pwdata};
        end
      end
      unique case (st)
        S_IDLE: begin
          if (start) begin
            q        <= req;
            r_status <= ST_REJ;
            r_id     <= '0;
            r_state  <= '0;
            r_prio   <= '0;
            r_exit   <= '0;
            r_fire   <= 1'b0;
            r_index  <= '0;
            cmd.target <= '0;
            cmd.state  <= '0;
            cmd.prio   <= req.priority_req;
            cmd.susp   <= req.create_held;
            cmd.ident  <= next_ident;
            cmd.val    <= {32'd0, req.thread_id};
            unique case (req.kind)
              K_CREATE: begin
                if (shut) begin
                  done <= 1'b1;
                end else begin
                  cmd.mode <= M_CREATE;
                  launch   <= 1'b1;
                  st       <= S_CREATE;
                end
              end
              K_RESUME, K_SUSPEND, K_CANCEL, K_QUERY: begin
                priority case (req.kind)
                  K_RESUME:  cmd.mode <= M_RESUME;
                  K_SUSPEND: cmd.mode <= M_SUSPEND;
                  K_CANCEL:  cmd.mode <= M_CANCEL;
                  default:   cmd.mode <= M_PROBE;
                endcase
                launch <= 1'b1;
                st     <= S_CLAIM;
              end
              K_SEND: begin
                cmd.mode <= M_PICK_WAITQ;
                cmd.val  <= req.queue_key;
                launch   <= 1'b1;
                st       <= S_SEND;
              end
              K_DISP: begin
                if (shut) begin
                  r_status <= ST_SHUT;
                  done     <= 1'b1;
                end else if (bg) begin
                  r_status <= ST_SUSP;
                  done     <= 1'b1;
                end else if (pending) begin
                  done <= 1'b1;
                end else begin
                  cmd.mode <= M_WAKE_DUE;
                  cmd.val  <= tick;
                  launch   <= 1'b1;
                  st       <= S_WAKE1;
                end
              end
              K_STEP: begin
                if (!pending) begin
                  done <= 1'b1;
                end else begin
                  // count the operation and tick now, check the slot next
                  pending <= 1'b0;
                  opcnt   <= opcnt + 64'd1;
                  tick    <= tick + 64'd1;
                  rd_idx  <= run_slot;
                  st      <= S_SLIVE;
                end
              end
              K_SHUT: begin
                shut     <= 1'b1;
                r_status <= ST_OK;
                cmd.mode <= M_SHUTDOWN;
                launch   <= 1'b1;
                st       <= S_LAST;
              end
              K_REAP: begin
                r_status <= ST_OK;
                cmd.mode <= M_REAP;
                launch   <= 1'b1;
                st       <= S_LAST;
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_CREATE: begin
          if (pass_done) begin
            if (tend.hit) begin
              r_status   <= ST_OK;
              r_id       <= next_ident;
              next_ident <= next_ident + 32'd1;
            end
            done <= 1'b1;
            st   <= S_IDLE;
          end
        end
        S_CLAIM: begin
          if (pass_done) begin
            if (q.kind == K_QUERY) begin
              if (tend.hit) begin
                rd_idx <= tend.best_idx;
                st     <= S_QREAD;
              end else begin
                done <= 1'b1;
                st   <= S_IDLE;
              end
            end else if (q.kind == K_CANCEL && tend.ok) begin
              // release threads joined on the cancelled one
              r_status <= ST_OK;
              cmd.mode <= M_WAKE_JOIN;
              launch   <= 1'b1;
              st       <= S_LAST;
            end else begin
              if (tend.ok) r_status <= ST_OK;
              done <= 1'b1;
              st   <= S_IDLE;
            end
          end
        end
        S_LAST: begin
          if (pass_done) begin
            done <= 1'b1;
            st   <= S_IDLE;
          end
        end
        S_QREAD: begin
          r_status <= ST_OK;
          r_id     <= rd.ident;
          r_state  <= rd.state;
          r_prio   <= rd.prio;
          r_exit   <= rd.exit_val;
          done     <= 1'b1;
          st       <= S_IDLE;
        end
        S_SEND: begin
          if (pass_done) begin
            if (tend.best_valid) begin
              r_status   <= ST_OK;
              cmd.mode   <= M_READY_AT;
              cmd.target <= tend.best_idx;
              launch     <= 1'b1;
              st         <= S_LAST;
            end else begin
              done <= 1'b1;
              st   <= S_IDLE;
            end
          end
        end
        S_WAKE1: begin
          if (pass_done) begin
            cmd.mode <= M_PICK_READY;
            launch   <= 1'b1;
            st       <= S_PICK;
          end
        end
        S_PICK: begin
          if (pass_done) begin
            if (tend.best_valid) begin
              cmd.mode   <= M_RUN_AT;
              cmd.target <= tend.best_idx;
              run_slot   <= tend.best_idx;
              rd_idx     <= tend.best_idx;
              pending    <= 1'b1;
              r_status   <= ST_DISP;
              launch     <= 1'b1;
              st         <= S_RUN;
            end else begin
              cmd.mode <= M_MIN_SLEEP;
              launch   <= 1'b1;
              st       <= S_MINS;
            end
          end
        end
        S_RUN: begin
          if (pass_done) begin
            run_ident <= rd.ident;
            r_id      <= rd.ident;
            done      <= 1'b1;
            st        <= S_IDLE;
          end
        end
        S_MINS: begin
          if (pass_done) begin
            if (!tend.best_valid) begin
              r_status <= ST_IDLE;
              done     <= 1'b1;
              st       <= S_IDLE;
            end else begin
              // jump time to the earliest alarm and wake what is due
              tick     <= alarm_tick;
              r_status <= ST_ALARM;
              cmd.mode <= M_WAKE_DUE;
              cmd.val  <= alarm_tick;
              launch   <= 1'b1;
              st       <= S_LAST;
            end
          end
        end
        S_SLIVE: begin
          cmd.target <= run_slot;
          cmd.val    <= q.action_value;
          if (shut) begin
            r_status <= ST_SHUT;
            if (live) begin
              cmd.mode  <= M_SET_AT;
              cmd.state <= TS_CANCELLED;
              launch    <= 1'b1;
              st        <= S_STEPW;
            end else begin
              st <= S_RET;
            end
          end else begin
            r_status <= ST_EXEC;
            if (!live) begin
              st <= S_RET;
            end else begin
              launch <= 1'b1;
              priority case (q.action_kind)
                A_SLEEP: begin
                  cmd.mode  <= M_SET_AT;
                  cmd.state <= TS_SLEEPING;
                  cmd.val   <= sleep_to;
                  st        <= S_STEPW;
                end
                A_WAITQ: begin
                  cmd.mode  <= M_SET_AT;
                  cmd.state <= TS_WAITQ;
                  st        <= S_STEPW;
                end
                A_JOIN: begin
                  cmd.mode <= M_PROBE;
                  st       <= S_SPROBE;
                end
                A_EXIT: begin
                  cmd.mode  <= M_SET_AT;
                  cmd.state <= TS_TERMINATED;
                  st        <= S_SEXIT;
                end
                default: begin
                  cmd.mode <= M_READY_AT;
                  st       <= S_STEPW;
                end
              endcase
            end
          end
        end
        S_SPROBE: begin
          if (pass_done) begin
            // a missing or finished join target leaves the thread ready
            if (tend.ok) begin
              cmd.mode  <= M_SET_AT;
              cmd.state <= TS_WAITJOIN;
            end else begin
              cmd.mode <= M_READY_AT;
            end
            launch <= 1'b1;
            st     <= S_STEPW;
          end
        end
        S_SEXIT: begin
          if (pass_done) begin
            cmd.mode <= M_WAKE_JOIN;
            cmd.val  <= {32'd0, run_ident};
            launch   <= 1'b1;
            st       <= S_STEPW;
          end
        end
        S_STEPW: begin
          if (pass_done) st <= S_RET;
        end
        S_RET: begin
          if (period != 32'd0 && opcnt >= next_at) begin
            r_fire  <= 1'b1;
            next_at <= next_at + {32'd0, period};
            div_go  <= 1'b1;
            st      <= S_DIV;
          end else begin
            done <= 1'b1;
            st   <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            r_index <= div_quot;
            done    <= 1'b1;
            st      <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_one_token: assert property (@(posedge clk) disable iff (rst) $onehot0(tok_vld))
    else $error("more than one pass in the cell row");
  a_launch_clear: assert property (@(posedge clk) disable iff (rst)
    launch |-> !pass_done)
    else $error("pass launched before the previous one left the row");
  a_div_fire: assert property (@(posedge clk) disable iff (rst) (st == S_DIV) |-> r_fire)
    else $error("divider running without a retrace event");
`endif

endmodule

@@ sim/tb_priority_thread_scheduler.sv @@
// Self-checking testbench for the priority thread scheduler: directed and random items,
// with APB register writes between phases. Depends on pts_pkg and priority_thread_scheduler.
`timescale 1ns / 100ps
module tb_priority_thread_scheduler;
  import pts_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 250;
  localparam int REQ_W          = $bits(pts_req_t);
  localparam logic [2:0] ADDR_BACKGROUND = 3'd0;
  localparam logic [2:0] ADDR_RETRACE    = 3'd4;

  logic        clk;
  logic        rst;
  logic        start = 1'b0;
  logic        busy;
  pts_req_t    req = '0;
  logic        done;
  pts_rsp_t    rsp;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  priority_thread_scheduler u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  // Scheduler shadow: thread table, counters and registers as the block should hold them
  logic        th_used  [MAX_THREADS];
  logic [31:0] th_id    [MAX_THREADS];
  logic [7:0]  th_prio  [MAX_THREADS];
  logic [2:0]  th_state [MAX_THREADS];
  logic [63:0] th_order [MAX_THREADS];
  logic [63:0] th_wake  [MAX_THREADS];
  logic [63:0] th_key   [MAX_THREADS];
  logic [63:0] th_exit  [MAX_THREADS];
  logic [31:0] nx_id = 32'd1;
  logic [63:0] nx_order = '0;
  logic [63:0] sched_tick = '0;
  logic [63:0] op_count = '0;
  logic [63:0] retrace_due = '0;
  logic        halted = 1'b0;
  int          run_slot = 0;
  logic        step_open = 1'b0;
  logic [31:0] run_id = '0;
  logic        bg_mode = 1'b0;
  logic [31:0] rt_period = '0;

  pts_req_t pending_items[$];
  pts_rsp_t expected_rsp[$];
  int       error_count = 0;
  int       idle_pct = 0;
  int       quiet_cycles = 0;

  initial begin
    for (int i = 0; i < MAX_THREADS; i++) th_used[i] = 1'b0;
  end

  function automatic void add_item(pts_req_t r);
    pending_items.insert(pending_items.size(), r);
  endfunction

  function automatic int find_thread(logic [63:0] id);
    for (int i = 0; i < MAX_THREADS; i++)
      if (th_used[i] && {32'd0, th_id[i]} == id) return i;
    return -1;
  endfunction

  function automatic bit finished(int i);
    return th_state[i] == TS_TERMINATED || th_state[i] == TS_CANCELLED;
  endfunction

  function automatic void make_ready(int i);
    th_state[i] = TS_READY;
    th_order[i] = nx_order;
    nx_order = nx_order + 64'd1;
    th_wake[i] = '0;
    th_key[i] = '0;
  endfunction

  function automatic void release_joiners(logic [31:0] target);
    for (int i = 0; i < MAX_THREADS; i++)
      if (th_used[i] && th_state[i] == TS_WAITJOIN && th_key[i] == {32'd0, target})
        make_ready(i);
  endfunction

  function automatic void wake_sleepers();
    for (int i = 0; i < MAX_THREADS; i++)
      if (th_used[i] && th_state[i] == TS_SLEEPING && th_wake[i] <= sched_tick)
        make_ready(i);
  endfunction

  // best candidate: lowest priority number, then oldest ready order
  function automatic int best_thread(logic [2:0] st, bit by_key, logic [63:0] key);
    int best;
    best = -1;
    for (int i = 0; i < MAX_THREADS; i++) begin
      if (!th_used[i] || th_state[i] != st) continue;
      if (by_key && th_key[i] != key) continue;
      if (best < 0 || th_prio[i] < th_prio[best] ||
          (th_prio[i] == th_prio[best] && th_order[i] < th_order[best]))
        best = i;
    end
    return best;
  endfunction

  function automatic void apply_register(logic [2:0] addr, logic [31:0] value);
    if (addr == ADDR_BACKGROUND) begin
      bg_mode = value[0];
    end else begin
      rt_period = value;
      retrace_due = op_count + {32'd0, value};
    end
  endfunction

  // Work out the one result an accepted item produces and update the shadow
  function automatic pts_rsp_t schedule_item(pts_req_t r);
    pts_rsp_t o;
    int s;
    int t;
    bit any;
    bit live;
    logic [63:0] earliest;
    o = '0;
    o.status = ST_REJ;
    case (r.kind)
      K_CREATE: begin
        s = -1;
        for (int i = 0; i < MAX_THREADS; i++)
          if (!th_used[i] && s < 0) s = i;
        if (!halted && s >= 0) begin
          th_used[s] = 1'b1;
          th_id[s] = nx_id;
          nx_id = nx_id + 32'd1;
          th_prio[s] = r.priority_req;
          th_wake[s] = '0;
          th_key[s] = '0;
          th_exit[s] = '0;
          if (r.create_held) begin
            th_state[s] = TS_SUSPENDED;
            th_order[s] = '0;
          end else begin
            th_state[s] = TS_READY;
            th_order[s] = nx_order;
            nx_order = nx_order + 64'd1;
          end
          o.result_id = th_id[s];
          o.status = ST_OK;
        end
      end
      K_RESUME: begin
        s = find_thread({32'd0, r.thread_id});
        if (s >= 0 && !finished(s)) begin
          make_ready(s);
          o.status = ST_OK;
        end
      end
      K_SUSPEND, K_CANCEL: begin
        s = find_thread({32'd0, r.thread_id});
        if (s >= 0 && !finished(s) && th_state[s] != TS_RUNNING) begin
          if (r.kind == K_SUSPEND) begin
            th_state[s] = TS_SUSPENDED;
          end else begin
            th_state[s] = TS_CANCELLED;
            release_joiners(th_id[s]);
          end
          o.status = ST_OK;
        end
      end
      K_SEND: begin
        s = best_thread(TS_WAITQ, 1'b1, r.queue_key);
        if (s >= 0) begin
          make_ready(s);
          o.status = ST_OK;
        end
      end
      K_DISP: begin
        if (halted) begin
          o.status = ST_SHUT;
        end else if (bg_mode) begin
          o.status = ST_SUSP;
        end else if (!step_open) begin
          wake_sleepers();
          s = best_thread(TS_READY, 1'b0, '0);
          if (s < 0) begin
            any = 1'b0;
            earliest = '0;
            for (int i = 0; i < MAX_THREADS; i++)
              if (th_used[i] && th_state[i] == TS_SLEEPING &&
                  (!any || th_wake[i] < earliest)) begin
                any = 1'b1;
                earliest = th_wake[i];
              end
            if (!any) begin
              o.status = ST_IDLE;
            end else begin
              if (earliest > sched_tick) sched_tick = earliest;
              wake_sleepers();
              o.status = ST_ALARM;
            end
          end else begin
            th_state[s] = TS_RUNNING;
            run_slot = s;
            run_id = th_id[s];
            step_open = 1'b1;
            o.result_id = run_id;
            o.status = ST_DISP;
          end
        end
      end
      K_STEP: begin
        if (step_open) begin
          step_open = 1'b0;
          op_count = op_count + 64'd1;
          sched_tick = sched_tick + 64'd1;
          s = run_slot;
          live = th_used[s] && th_id[s] == run_id;
          if (halted) begin
            if (live) th_state[s] = TS_CANCELLED;
            o.status = ST_SHUT;
          end else begin
            o.status = ST_EXEC;
            if (live) begin
              case (r.action_kind)
                A_SLEEP: begin
                  th_state[s] = TS_SLEEPING;
                  th_wake[s] = r.action_value > sched_tick ? r.action_value : sched_tick;
                end
                A_WAITQ: begin
                  th_state[s] = TS_WAITQ;
                  th_key[s] = r.action_value;
                end
                A_JOIN: begin
                  t = find_thread(r.action_value);
                  if (t < 0 || finished(t)) begin
                    make_ready(s);
                  end else begin
                    th_state[s] = TS_WAITJOIN;
                    th_key[s] = r.action_value;
                  end
                end
                A_EXIT: begin
                  th_state[s] = TS_TERMINATED;
                  th_exit[s] = r.action_value;
                  release_joiners(th_id[s]);
                end
                default: make_ready(s);
              endcase
            end
          end
          if (rt_period != 0 && op_count >= retrace_due) begin
            o.retrace_fire = 1'b1;
            o.retrace_count = op_count / {32'd0, rt_period};
            retrace_due = retrace_due + {32'd0, rt_period};
          end
        end
      end
      K_SHUT: begin
        halted = 1'b1;
        for (int i = 0; i < MAX_THREADS; i++)
          if (th_used[i] && th_state[i] != TS_TERMINATED) th_state[i] = TS_CANCELLED;
        o.status = ST_OK;
      end
      K_REAP: begin
        for (int i = 0; i < MAX_THREADS; i++)
          if (th_used[i] && finished(i)) th_used[i] = 1'b0;
        o.status = ST_OK;
      end
      K_QUERY: begin
        s = find_thread({32'd0, r.thread_id});
        if (s >= 0) begin
          o.result_id = th_id[s];
          o.thread_state = th_state[s];
          o.thread_priority = th_prio[s];
          o.exit_value = th_exit[s];
          o.status = ST_OK;
        end
      end
      default: ;
    endcase
    o.logical_tick = sched_tick;
    return o;
  endfunction

  function automatic pts_req_t make_item(logic [3:0] kind, logic [31:0] id, logic [7:0] prio,
                                         logic susp, logic [63:0] key, logic [2:0] act,
                                         logic [63:0] val);
    pts_req_t r;
    r.kind = kind;
    r.thread_id = id;
    r.priority_req = prio;
    r.create_held = susp;
    r.queue_key = key;
    r.action_kind = act;
    r.action_value = val;
    return r;
  endfunction

  function automatic logic [31:0] pick_id();
    if ($urandom_range(0, 99) < 85) return 32'($urandom_range(0, nx_id + 1));
    return $urandom;
  endfunction

  function automatic logic [63:0] pick_key();
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
    return 64'($urandom_range(0, 3));
  endfunction

  // Random item with random filler in unused fields; dispatch and step are the most frequent kinds
  function automatic pts_req_t random_item();
    pts_req_t r;
    int sel;
    r = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    sel = $urandom_range(0, 99);
    if (sel < 14) begin
      r.kind = K_CREATE;
      if ($urandom_range(0, 9) < 7) r.priority_req = 8'($urandom_range(0, 3));
      r.create_held = ($urandom_range(0, 4) == 0);
    end else if (sel < 34) begin
      r.kind = K_DISP;
    end else if (sel < 56) begin
      r.kind = K_STEP;
      r.action_kind = 3'($urandom_range(0, 7));
      case (r.action_kind)
        A_SLEEP: begin
          if ($urandom_range(0, 49) == 0) r.action_value = {$urandom, $urandom};
          else r.action_value = sched_tick + 64'($urandom_range(0, 20));
        end
        A_WAITQ: r.action_value = pick_key();
        A_JOIN: r.action_value = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                                               : {32'd0, pick_id()};
        default: ;
      endcase
    end else if (sel < 63) begin
      r.kind = K_RESUME;
      r.thread_id = pick_id();
    end else if (sel < 69) begin
      r.kind = K_SUSPEND;
      r.thread_id = pick_id();
    end else if (sel < 74) begin
      r.kind = K_CANCEL;
      r.thread_id = pick_id();
    end else if (sel < 81) begin
      r.kind = K_SEND;
      r.queue_key = pick_key();
    end else if (sel < 89) begin
      r.kind = K_QUERY;
      r.thread_id = pick_id();
    end else if (sel < 93) begin
      r.kind = K_REAP;
    end else if (sel < 95) begin
      r.kind = 4'($urandom_range(int'(K_QUERY) + 1, 15));
    end else begin
      r.kind = K_QUERY;
      r.thread_id = $urandom;
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, field, got, want);
    error_count++;
  endtask

  // Clock and the single reset at the start of the run
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  // Driver: hold start while busy, otherwise present the next item or idle at random
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_rsp.insert(expected_rsp.size(), schedule_item(req));
      if (!start || !busy) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          start <= 1'b1;
          req <= pending_items.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe is one result transfer, checked against the oldest expectation
  always @(posedge clk) begin
    pts_rsp_t want;
    if (!rst && done) begin
      if (expected_rsp.size() == 0) begin
        $display("[%0t] result transfer with nothing expected", $time);
        error_count++;
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.status !== want.status)
          report_mismatch("status", 64'(rsp.status), 64'(want.status));
        if (rsp.result_id !== want.result_id)
          report_mismatch("result_id", 64'(rsp.result_id), 64'(want.result_id));
        if (rsp.thread_state !== want.thread_state)
          report_mismatch("thread_state", 64'(rsp.thread_state), 64'(want.thread_state));
        if (rsp.thread_priority !== want.thread_priority)
          report_mismatch("thread_priority", 64'(rsp.thread_priority), 64'(want.thread_priority));
        if (rsp.exit_value !== want.exit_value)
          report_mismatch("exit_value", rsp.exit_value, want.exit_value);
        if (rsp.retrace_fire !== want.retrace_fire)
          report_mismatch("retrace_fire", 64'(rsp.retrace_fire), 64'(want.retrace_fire));
        if (rsp.retrace_count !== want.retrace_count)
          report_mismatch("retrace_count", rsp.retrace_count, want.retrace_count);
        if (rsp.logical_tick !== want.logical_tick)
          report_mismatch("logical_tick", rsp.logical_tick, want.logical_tick);
      end
    end
  end

  // Watchdog: count cycles with no transfer in either direction
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // APB write: setup cycle, then access cycle; the register takes the value at its end
  task automatic write_register(logic [2:0] addr, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    apply_register(addr, value);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every queued item has been transferred and answered, then let the block settle
  task automatic drain();
    while (pending_items.size() > 0 || start || expected_rsp.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Feed random items a few at a time so they follow the live shadow state
  task automatic run_random(int count, int pct);
    int made;
    made = 0;
    idle_pct = pct;
    while (made < count) begin
      @(posedge clk);
      if (pending_items.size() < 2) begin
        add_item(random_item());
        made++;
      end
    end
    drain();
  endtask

  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    repeat (2) @(posedge clk);

    // Directed: priority ties, dispatch while a step is open, sleep with alarm jump,
    // join released by exit, wait queue and send, reject paths
    idle_pct = 0;
    add_item(make_item(K_CREATE, '0, 8'd0, 1'b0, '0, A_YIELD, '0));
    add_item(make_item(K_CREATE, '1, 8'd255, 1'b1, '1, A_EXIT, '1));
    add_item(make_item(K_CREATE, '0, 8'd0, 1'b0, '0, A_YIELD, '0));
    add_item(make_item(K_QUERY, 32'd1, '0, 1'b0, '0, A_YIELD, '0));
    add_item(make_item(K_DISP, '0, '0, 1'b0, '0, A_YIELD, '0));
    add_item(make_item(K_DISP, '0, '0, 1'b0, '0, A_YIELD, '0));
    add_item(make_item(K_STEP, '0, '0, 1'b0, '0, A_YIELD, '0));
    add_item(make_item(K_DISP, '0, '0, 1'b0, '0, A_YIELD, '0));
    add_item(make_item(K_STEP, '0, '0, 1'b0, '0, A_SLEEP, 64'd10));
    add_item(make_item(K_DISP, '0, '0, 1'b0, '0, A_YIELD, '0));
    add_item(make_item(K_STEP, '0, '0, 1'b0, '0, A_JOIN, 64'd3));
    add_item(make_item(K_DISP, '0, '0, 1'b0, '0, A_YIELD, '0));
    add_item(make_item(K_DISP, '0, '0, 1'b0, '0, A_YIELD, '0));
    add_item(make_item(K_STEP, '0, '0, 1'b0, '0, A_EXIT, '1));
    add_item(make_item(K_QUERY, 32'd3, '0, 1'b0, '0, A_YIELD, '0));
    add_item(make_item(K_RESUME, 32'd2, '0, 1'b0, '0, A_YIELD, '0));
    add_item(make_item(K_SUSPEND, '1, '0, 1'b0, '0, A_YIELD, '0));
    add_item(make_item(K_SEND, '0, '0, 1'b0, '0, A_YIELD, '0));
    add_item(make_item(K_DISP, '0, '0, 1'b0, '0, A_YIELD, '0));
    add_item(make_item(K_STEP, '0, '0, 1'b0, '0, A_WAITQ, 64'hA5A5_5A5A_F00D_0001));
    add_item(make_item(K_SEND, '0, '0, 1'b0, 64'hA5A5_5A5A_F00D_0001, A_YIELD, '0));
    add_item(make_item(K_CANCEL, 32'd2, '0, 1'b0, '0, A_YIELD, '0));
    add_item(make_item(K_REAP, '0, '0, 1'b0, '0, A_YIELD, '0));
    add_item(make_item(K_STEP, '0, '0, 1'b0, '0, A_YIELD, '0));
    drain();

    // Retrace every operation, no idling
    write_register(ADDR_RETRACE, 32'd1);
    run_random(150, 0);
    // Sender mostly idle, period three
    write_register(ADDR_RETRACE, 32'd3);
    run_random(150, 77);
    // Background mode and the largest period
    write_register(ADDR_BACKGROUND, 32'd1);
    write_register(ADDR_RETRACE, 32'hFFFF_FFFF);
    run_random(50, 8);
    write_register(ADDR_BACKGROUND, 32'd0);
    write_register(ADDR_RETRACE, 32'd7);
    run_random(140, 8);
    write_register(ADDR_RETRACE, 32'd0);
    run_random(130, 0);

    // Shutdown with a step still open, then everything after it
    write_register(ADDR_RETRACE, 32'd2);
    add_item(make_item(K_REAP, '0, '0, 1'b0, '0, A_YIELD, '0));
    add_item(make_item(K_CREATE, '0, 8'd9, 1'b0, '0, A_YIELD, '0));
    add_item(make_item(K_DISP, '0, '0, 1'b0, '0, A_YIELD, '0));
    add_item(make_item(K_SHUT, '0, '0, 1'b0, '0, A_YIELD, '0));
    add_item(make_item(K_STEP, '0, '0, 1'b0, '0, A_EXIT, 64'd5));
    add_item(make_item(K_CREATE, '0, 8'd1, 1'b0, '0, A_YIELD, '0));
    add_item(make_item(K_DISP, '0, '0, 1'b0, '0, A_YIELD, '0));
    run_random(30, 8);

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/pts_pkg.sv
sv/pts_cell.sv
sv/pts_div.sv
sv/priority_thread_scheduler.sv
sim/tb_priority_thread_scheduler.sv
